// File: rtl/gdr_pkg.sv
// Shared types, constants and command codes for the grid DDA ray caster.
package gdr_pkg;

  localparam int MAP_SIZE_DEF = 64;
  localparam int ONE_Q10 = 1024;
  localparam logic [19:0] DIST_MAX = 20'hFFFFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  typedef struct packed {
    logic command;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic cell_solid;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } cmd_word_t;

  typedef struct packed {
    logic [5:0] hit_x;
    logic [5:0] hit_y;
    logic side;
    logic [19:0] distance;
    logic outside;
  } result_word_t;

  typedef enum logic [1:0] {
    RES_OUTSIDE,
    RES_START,
    RES_HIT
  } res_kind_t;

  typedef struct packed {
    logic clear;
    logic write;
    logic load;
    logic setup;
    logic step;
    logic div_start;
    logic res_load;
    res_kind_t res_kind;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic start_bad;
    logic solid;
    logic first;
    logic left_map;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/gdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gdr_divider.sv
// Restoring divider that yields floor((num << 14) / den), one quotient bit per cycle.
module gdr_divider #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [NUM_W+13:0]  quot
);

  localparam int QW = NUM_W + 14;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]    quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W-1:0] rem_new;

  always_comb begin
    rem_sh = {rem, quo[QW-1]};
    fits = rem_sh >= {1'b0, dv};
    rem_new = fits ? DEN_W'(rem_sh - {1'b0, dv}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= {num, 14'b0};
        rem <= '0;
        dv <= den;
        cnt <= CW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[QW-2:0], fits};
        rem <= rem_new;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = quo;

endmodule

// File: rtl/gdr_datapath.sv
// Datapath: map memory, ray state, step comparison, distance divider and output register.
module gdr_datapath #(
  parameter int MAP_SIZE = gdr_pkg::MAP_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gdr_pkg::cmd_word_t    in_word,
  input  gdr_pkg::dp_cmd_t      cmd,
  output gdr_pkg::dp_stat_t     stat,
  input  logic                  out_stall,
  output logic                  out_valid,
  output gdr_pkg::result_word_t out_word
);
  import gdr_pkg::*;

  localparam int AW = $clog2(MAP_SIZE);
  localparam int RAW = 2 * AW;
  localparam int DEPTH = 1 << RAW;
  localparam int XW = AW + 2;
  localparam int NW = $clog2(MAP_SIZE + 2) + 10;
  localparam int PW = NW + 16;
  localparam int QW = NW + 14;

  logic [15:0]     px, py, adx, ady;
  logic            neg_x, neg_y;
  logic [XW-1:0]   cx, cy;
  logic [NW-1:0]   nx, ny;
  logic [PW-1:0]   prod_x, prod_y;
  logic            sd;
  logic            first;
  logic [RAW-1:0]  rd_addr;
  logic [RAW-1:0]  clr_cnt;
  result_word_t    res;

  logic            take_x;
  logic [XW-1:0]   cx_next, cy_next;
  logic            left_map;
  logic [RAW-1:0]  start_addr, step_addr, raddr, waddr;
  logic            wr_ok, we, wdata, solid;
  logic [NW-1:0]   div_num;
  logic [15:0]     div_den;
  logic            div_done;
  logic [QW-1:0]   quot;
  logic [19:0]     wall_dist;

  always_comb begin
    take_x = prod_x < prod_y;
    cx_next = take_x ? cx + (neg_x ? {XW{1'b1}} : XW'(1)) : cx;
    cy_next = take_x ? cy : cy + (neg_y ? {XW{1'b1}} : XW'(1));
    left_map = cx_next[XW-1] || (cx_next >= XW'(MAP_SIZE)) ||
               cy_next[XW-1] || (cy_next >= XW'(MAP_SIZE));
    start_addr = {AW'(py[15:10]), AW'(px[15:10])};
    step_addr = {cy_next[AW-1:0], cx_next[AW-1:0]};
    if (cmd.setup) begin
      raddr = start_addr;
    end else if (cmd.step) begin
      raddr = step_addr;
    end else begin
      raddr = rd_addr;
    end
    wr_ok = cmd.write && (int'(in_word.cell_x) < MAP_SIZE) &&
            (int'(in_word.cell_y) < MAP_SIZE);
    we = cmd.clear || wr_ok;
    waddr = cmd.clear ? clr_cnt : {AW'(in_word.cell_y), AW'(in_word.cell_x)};
    wdata = cmd.clear ? 1'b0 : in_word.cell_solid;
    div_num = sd ? ny - NW'(ONE_Q10) : nx - NW'(ONE_Q10);
    div_den = sd ? ady : adx;
    wall_dist = (quot > QW'(DIST_MAX)) ? DIST_MAX : quot[19:0];
  end

  gdr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (solid)
  );

  gdr_divider #(.NUM_W(NW), .DEN_W(16)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + RAW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    rd_addr <= raddr;
    prod_x <= PW'(nx) * PW'(ady);
    prod_y <= PW'(ny) * PW'(adx);
    if (cmd.load) begin
      px <= in_word.pos_x;
      py <= in_word.pos_y;
      adx <= in_word.dir_x[15] ? 16'(-in_word.dir_x) : 16'(in_word.dir_x);
      ady <= in_word.dir_y[15] ? 16'(-in_word.dir_y) : 16'(in_word.dir_y);
      neg_x <= in_word.dir_x[15];
      neg_y <= in_word.dir_y[15];
    end
    if (cmd.setup) begin
      cx <= XW'(px[15:10]);
      cy <= XW'(py[15:10]);
      nx <= neg_x ? NW'(px[9:0]) : NW'(11'd1024 - {1'b0, px[9:0]});
      ny <= neg_y ? NW'(py[9:0]) : NW'(11'd1024 - {1'b0, py[9:0]});
      first <= 1'b1;
      sd <= 1'b0;
    end
    if (cmd.step) begin
      cx <= cx_next;
      cy <= cy_next;
      if (take_x) begin
        nx <= nx + NW'(ONE_Q10);
      end else begin
        ny <= ny + NW'(ONE_Q10);
      end
      sd <= !take_x;
      first <= 1'b0;
    end
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_START: begin
          res <= '{hit_x: 6'(cx), hit_y: 6'(cy), side: 1'b0, distance: '0, outside: 1'b0};
        end
        RES_HIT: begin
          res <= '{hit_x: 6'(cx), hit_y: 6'(cy), side: sd, distance: wall_dist,
                   outside: 1'b0};
        end
        default: begin
          res <= '{hit_x: '0, hit_y: '0, side: 1'b0, distance: '0, outside: 1'b1};
        end
      endcase
    end
    if (cmd.emit) begin
      out_word <= res;
    end
  end

  always_comb begin
    stat.clear_done = &clr_cnt;
    stat.start_bad = (adx == 16'd0 && ady == 16'd0) ||
                     (int'(px[15:10]) >= MAP_SIZE) || (int'(py[15:10]) >= MAP_SIZE);
    stat.solid = solid;
    stat.first = first;
    stat.left_map = left_map;
    stat.div_done = div_done;
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

// File: rtl/gdr_controller.sv
// Controller state machine that sequences map clearing, writes and the ray walk.
module gdr_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_stall,
  output gdr_pkg::dp_cmd_t  cmd,
  input  gdr_pkg::dp_stat_t stat
);
  import gdr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_STEP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.res_kind = RES_OUTSIDE;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_CAST) begin
            cmd.load = 1'b1;
            state_next = S_SETUP;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.start_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_OUTSIDE;
          state_next = S_EMIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.solid) begin
          if (stat.first) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_START;
            state_next = S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.left_map) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_OUTSIDE;
          state_next = S_EMIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_HIT;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/grid_dda_ray_caster.sv
// Top level of the grid DDA ray caster: controller and datapath.
// A cast accepts the word, runs the setup, tests the start cell, handles each further
// cell the ray steps through (product registers, then compare and map read), and, on
// a wall hit past the start cell, runs a divider that yields one quotient bit per
// cycle, then loads the output word, which waits while a previous result word is
// stalled. After reset, a clearing pass writes every map entry, 2^(2*clog2(MAP_SIZE))
// entries (4096 at MAP_SIZE 64), during which no input word is accepted.
module grid_dda_ray_caster #(
  parameter int MAP_SIZE = gdr_pkg::MAP_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gdr_pkg::cmd_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gdr_pkg::result_word_t out_word
);
  import gdr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gdr_controller u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_word.command),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  gdr_datapath #(.MAP_SIZE(MAP_SIZE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// File: rtl/gdr_checker.sv
// Port-level assertions for the ray caster, bound to the top level.
module gdr_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input gdr_pkg::cmd_word_t    in_word,
  input logic                  out_valid,
  input logic                  out_stall,
  input gdr_pkg::result_word_t out_word
);
  import gdr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_word))
    else $error("stalled result word changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.outside |-> out_word.hit_x == 6'd0 && out_word.hit_y == 6'd0 &&
      !out_word.side && out_word.distance == 20'd0)
    else $error("outside result carries nonzero fields");

  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_word.command == CMD_CAST |=> in_stall)
    else $error("new word accepted right after a cast");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not stalled for clearing after reset");

endmodule

bind grid_dda_ray_caster gdr_checker u_chk (.*);
